/* rtl/format_string_printer_unit_defines.svh */
// Assertion macros used by the format string printer controller.
`ifndef FORMAT_STRING_PRINTER_UNIT_DEFINES_SVH
`define FORMAT_STRING_PRINTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fsp_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
`default_nettype none
package fsp_pkg;

    localparam int MAX_WIDTH     = 32;
    localparam int WIDTH_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int CHAR_BITS     = 8;
    localparam int ARG_BITS      = 32;
    localparam int COUNT_BITS    = 31;
    localparam int BCD_DIGITS    = 10;
    localparam int NDIG_BITS     = 4;
    localparam int STEP_BITS     = $clog2(ARG_BITS + 1);
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 40;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [CHAR_BITS-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_D       = 8'h64;
    localparam logic [CHAR_BITS-1:0] CH_U       = 8'h75;
    localparam logic [CHAR_BITS-1:0] CH_X       = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_C       = 8'h63;
    localparam logic [CHAR_BITS-1:0] CH_N       = 8'h6E;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_HEX_OFS = 8'h57;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_NONE  = 2'd0;
    localparam t_kind KIND_BYTE  = 2'd1;
    localparam t_kind KIND_COUNT = 2'd2;
    localparam t_kind KIND_NUM   = 2'd3;

    typedef logic [2:0] t_src;
    localparam t_src SRC_CHAR  = 3'd0;
    localparam t_src SRC_COUNT = 3'd1;
    localparam t_src SRC_SIGN  = 3'd2;
    localparam t_src SRC_PAD   = 3'd3;
    localparam t_src SRC_DIGIT = 3'd4;

    typedef struct packed {
        logic load_in;
        logic decode;
        logic step;
        logic prep;
        logic emit;
        t_src src;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  neg;
        logic  conv_done;
        logic  pad_zero;
        logic  idx_zero;
        logic  out_free;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/fsp_datapath.sv */
// Parse state, number conversion and output register of the printer.
`default_nettype none
module fsp_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [fsp_pkg::CHAR_BITS-1:0]  i_fmt_char,
    input  wire logic [fsp_pkg::ARG_BITS-1:0]   i_arg_value,
    input  wire logic                           i_first,
    input  wire fsp_pkg::t_cmd                  i_cmd,
    output fsp_pkg::t_stat                      o_stat,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [fsp_pkg::CHAR_BITS-1:0]       o_out_char,
    output logic                                o_is_count,
    output logic [fsp_pkg::COUNT_BITS-1:0]      o_count,
    output logic                                o_last
);
    import fsp_pkg::*;

    localparam logic [1:0] MODE_LITERAL = 2'd0;
    localparam logic [1:0] MODE_SPEC    = 2'd1;
    localparam logic [1:0] MODE_WIDTH   = 2'd2;
    localparam int WMUL_BITS = WIDTH_BITS + 4;
    localparam int CMP_BITS  = WIDTH_BITS + NDIG_BITS;
    localparam int BCD_BITS  = 4 * BCD_DIGITS;

    logic [CHAR_BITS-1:0]   r_char;
    logic [ARG_BITS-1:0]    r_arg;
    logic [1:0]             r_mode;
    logic                   r_zero;
    logic [WIDTH_BITS-1:0]  r_width;
    logic [COUNT_BITS-1:0]  r_count;
    logic [ARG_BITS-1:0]    r_val;
    logic [BCD_BITS-1:0]    r_digits;
    logic [STEP_BITS-1:0]   r_step;
    logic                   r_hex;
    logic [CHAR_BITS-1:0]   r_byte;
    logic [WIDTH_BITS-1:0]  r_pad;
    logic [NDIG_BITS-1:0]   r_idx;
    logic                   r_o_valid;
    logic [CHAR_BITS-1:0]   r_o_char;
    logic                   r_o_is_count;
    logic [COUNT_BITS-1:0]  r_o_count;
    logic                   r_o_last;

    logic                   is_digit;
    logic [WMUL_BITS-1:0]   w_ext;
    logic [WIDTH_BITS-1:0]  w_sat;
    t_kind                  d_kind;
    logic                   d_neg;
    logic                   d_hex;
    logic [CHAR_BITS-1:0]   d_byte;
    logic [1:0]             d_mode;
    logic                   d_zero;
    logic [WIDTH_BITS-1:0]  d_width;
    logic [ARG_BITS-1:0]    mag;
    logic [BCD_BITS-1:0]    bcd_adj;
    logic [NDIG_BITS-1:0]   ndig;
    logic [CMP_BITS-1:0]    pad_calc;
    logic [3:0]             dig_sel;
    logic [CHAR_BITS-1:0]   dig_char;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   out_free;
    logic                   n_o_last;
    logic                   n_o_is_count;
    logic [CHAR_BITS-1:0]   n_o_char;

    assign is_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign w_ext = WMUL_BITS'(r_width) * WMUL_BITS'(10)
                 + WMUL_BITS'(r_char - CH_ZERO);
    assign w_sat = (w_ext > WMUL_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH)
                                                    : w_ext[WIDTH_BITS-1:0];

    always_comb begin
        d_kind  = KIND_NONE;
        d_neg   = 1'b0;
        d_hex   = 1'b0;
        d_byte  = r_char;
        d_mode  = r_mode;
        d_zero  = r_zero;
        d_width = r_width;
        priority if (r_mode == MODE_LITERAL) begin
            if (r_char == CH_PERCENT) begin
                d_mode  = MODE_SPEC;
                d_zero  = 1'b0;
                d_width = '0;
            end else begin
                d_kind = KIND_BYTE;
            end
        end else if ((r_mode == MODE_SPEC) && (r_char == CH_ZERO)) begin
            d_zero = 1'b1;
            d_mode = MODE_WIDTH;
        end else if (is_digit) begin
            d_width = w_sat;
            d_mode  = MODE_WIDTH;
        end else begin
            d_mode = MODE_LITERAL;
            unique case (r_char)
                CH_D: begin
                    d_kind = KIND_NUM;
                    d_neg  = r_arg[ARG_BITS-1];
                end
                CH_U: d_kind = KIND_NUM;
                CH_X: begin
                    d_kind = KIND_NUM;
                    d_hex  = 1'b1;
                end
                CH_C: begin
                    d_kind = KIND_BYTE;
                    d_byte = r_arg[CHAR_BITS-1:0];
                end
                CH_PERCENT: begin
                    d_kind = KIND_BYTE;
                    d_byte = CH_PERCENT;
                end
                CH_N:    d_kind = KIND_COUNT;
                default: d_kind = KIND_NONE;
            endcase
        end
    end

    assign mag = d_neg ? (~r_arg + ARG_BITS'(1)) : r_arg;

    // Shift-and-add-three step of the binary to BCD conversion.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_digits[4*i +: 4] >= 4'd5) ? (r_digits[4*i +: 4] + 4'd3)
                                                            : r_digits[4*i +: 4];
        end
    end

    // Number of significant digits; a zero value still has one.
    always_comb begin
        ndig = NDIG_BITS'(1);
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_digits[4*i +: 4] != 4'd0) begin
                ndig = NDIG_BITS'(i + 1);
            end
        end
    end

    assign pad_calc = (CMP_BITS'(r_width) > CMP_BITS'(ndig))
                    ? (CMP_BITS'(r_width) - CMP_BITS'(ndig)) : '0;

    assign dig_sel  = r_digits[{r_idx, 2'b00} +: 4];
    assign dig_char = (dig_sel < 4'd10) ? (CH_ZERO + CHAR_BITS'(dig_sel))
                                        : (CH_HEX_OFS + CHAR_BITS'(dig_sel));

    assign count_inc = (r_count == COUNT_MAX) ? r_count : (r_count + COUNT_BITS'(1));
    assign out_free  = !r_o_valid || i_out_ready;

    always_comb begin
        n_o_char     = r_byte;
        n_o_is_count = 1'b0;
        n_o_last     = 1'b1;
        unique case (i_cmd.src)
            SRC_CHAR: n_o_char = r_byte;
            SRC_COUNT: begin
                n_o_char     = '0;
                n_o_is_count = 1'b1;
            end
            SRC_SIGN: begin
                n_o_char = CH_MINUS;
                n_o_last = 1'b0;
            end
            SRC_PAD: begin
                n_o_char = r_zero ? CH_ZERO : CH_SPACE;
                n_o_last = 1'b0;
            end
            SRC_DIGIT: begin
                n_o_char = dig_char;
                n_o_last = (r_idx == '0);
            end
            default: begin
                n_o_char = r_byte;
                n_o_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LITERAL;
            r_zero  <= 1'b0;
            r_width <= '0;
            r_count <= '0;
        end else if (i_cmd.load_in && i_first) begin
            r_mode  <= MODE_LITERAL;
            r_zero  <= 1'b0;
            r_width <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.decode) begin
                r_mode  <= d_mode;
                r_zero  <= d_zero;
                r_width <= d_width;
            end
            if (i_cmd.emit && !n_o_is_count) begin
                r_count <= count_inc;
            end
        end
    end

    // The byte to print is captured at decode, before the parse mode moves on.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_char <= i_fmt_char;
            r_arg  <= i_arg_value;
        end
        if (i_cmd.decode) begin
            r_hex  <= d_hex;
            r_byte <= d_byte;
            r_step <= '0;
            if (d_hex) begin
                r_digits <= BCD_BITS'(r_arg);
                r_val    <= '0;
            end else begin
                r_digits <= '0;
                r_val    <= mag;
            end
        end else if (i_cmd.step) begin
            r_digits <= {bcd_adj[BCD_BITS-2:0], r_val[ARG_BITS-1]};
            r_val    <= {r_val[ARG_BITS-2:0], 1'b0};
            r_step   <= r_step + STEP_BITS'(1);
        end
        if (i_cmd.prep) begin
            r_pad <= pad_calc[WIDTH_BITS-1:0];
            r_idx <= ndig - NDIG_BITS'(1);
        end else if (i_cmd.emit && (i_cmd.src == SRC_PAD)) begin
            r_pad <= r_pad - WIDTH_BITS'(1);
        end else if (i_cmd.emit && (i_cmd.src == SRC_DIGIT) && (r_idx != '0)) begin
            r_idx <= r_idx - NDIG_BITS'(1);
        end
    end

    // Output register: a result waits here while the next one is prepared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_char     <= n_o_char;
            r_o_is_count <= n_o_is_count;
            r_o_count    <= n_o_is_count ? r_count : count_inc;
            r_o_last     <= n_o_last;
        end
    end

    assign o_stat.kind      = d_kind;
    assign o_stat.neg       = d_neg;
    assign o_stat.conv_done = r_hex || (r_step == STEP_BITS'(ARG_BITS));
    assign o_stat.pad_zero  = (r_pad == '0);
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.out_free  = out_free;

    assign o_out_valid = r_o_valid;
    assign o_out_char  = r_o_char;
    assign o_is_count  = r_o_is_count;
    assign o_count     = r_o_count;
    assign o_last      = r_o_last;

endmodule
`default_nettype wire

/* rtl/fsp_ctrl.sv */
// Sequencing state machine of the format string printer.
`default_nettype none
`include "format_string_printer_unit_defines.svh"
module fsp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire fsp_pkg::t_stat i_stat,
    output fsp_pkg::t_cmd       o_cmd
);
    import fsp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_BYTE   = 3'd2;
    localparam logic [2:0] ST_COUNT  = 3'd3;
    localparam logic [2:0] ST_SIGN   = 3'd4;
    localparam logic [2:0] ST_CONV   = 3'd5;
    localparam logic [2:0] ST_PAD    = 3'd6;
    localparam logic [2:0] ST_DIGIT  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accepted;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accepted   = o_s_tready && i_s_tvalid;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.src     = SRC_CHAR;
        o_cmd.load_in = accepted;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                unique case (i_stat.kind)
                    KIND_BYTE:  n_state = ST_BYTE;
                    KIND_COUNT: n_state = ST_COUNT;
                    KIND_NUM:   n_state = i_stat.neg ? ST_SIGN : ST_CONV;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_BYTE: begin
                o_cmd.src = SRC_CHAR;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_COUNT: begin
                o_cmd.src = SRC_COUNT;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_SIGN: begin
                o_cmd.src = SRC_SIGN;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                if (i_stat.conv_done) begin
                    o_cmd.prep = 1'b1;
                    n_state    = ST_PAD;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_PAD: begin
                o_cmd.src = SRC_PAD;
                if (i_stat.pad_zero) begin
                    n_state = ST_DIGIT;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            ST_DIGIT: begin
                o_cmd.src = SRC_DIGIT;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.idx_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `FSP_ASSERT_SAME(a_emit_slot_free, i_clk, i_rst_n, o_cmd.emit, i_stat.out_free, "result written over a pending transfer")
    `FSP_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, accepted, r_state == ST_DECODE, "accepted item not decoded next")
    `FSP_ASSERT_NEXT(a_conv_hold, i_clk, i_rst_n, (r_state == ST_CONV) && !i_stat.conv_done, r_state == ST_CONV, "conversion left early")

endmodule
`default_nettype wire

/* rtl/format_string_printer_unit.sv */
// Top level of the format string printer: stream ports, controller and datapath.
// A literal byte passes the decode and byte states on its way into the output register.
// The input takes a new format byte only when idle, after the last one's bytes are written;
// decimal conversions go through a bit-serial BCD unit, hex conversions skip it,
// and output stalls hold the controller in its emitting states.
// Synchronous active-low reset clears the parse state, count and output valid.
`default_nettype none
module format_string_printer_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: fmt_char [7:0], arg_value [39:8]
    input  wire logic [fsp_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // tuser: first_of_string [0]
    input  wire logic                              i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata: out_char [7:0], count [38:8], zero [39]
    output logic [fsp_pkg::OUT_DATA_BITS-1:0]      o_m_axis_tdata,
    // tuser: is_count [0]
    output logic                                   o_m_axis_tuser,
    output logic                                   o_m_axis_tlast
);
    import fsp_pkg::*;

    t_cmd                  cmd;
    t_stat                 stat;
    logic [CHAR_BITS-1:0]  out_char;
    logic [COUNT_BITS-1:0] out_count;

    fsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fsp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fmt_char  (i_s_axis_tdata[CHAR_BITS-1:0]),
        .i_arg_value (i_s_axis_tdata[CHAR_BITS +: ARG_BITS]),
        .i_first     (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_char  (out_char),
        .o_is_count  (o_m_axis_tuser),
        .o_count     (out_count),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_BITS - CHAR_BITS - COUNT_BITS){1'b0}},
                             out_count, out_char};

endmodule
`default_nettype wire

/* dv/format_string_printer_unit_checker.sv */
// Checker for the format string printer: predicts each output byte and compares transfers.
`timescale 1ns / 100ps
module format_string_printer_unit_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              i_s_tready,
    // tdata: fmt_char [7:0], arg_value [39:8]
    input  wire logic [fsp_pkg::IN_DATA_BITS-1:0]  i_s_tdata,
    // tuser: first_of_string [0]
    input  wire logic                              i_s_tuser,
    input  wire logic                              i_m_tvalid,
    input  wire logic                              i_m_tready,
    // tdata: out_char [7:0], count [38:8], zero [39]
    input  wire logic [fsp_pkg::OUT_DATA_BITS-1:0] i_m_tdata,
    // tuser: is_count [0]
    input  wire logic                              i_m_tuser,
    input  wire logic                              i_m_tlast,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import fsp_pkg::*;

    typedef enum logic [1:0] {
        PM_LITERAL,
        PM_SPEC,
        PM_WIDTH
    } t_parse_mode;

    typedef struct packed {
        logic [CHAR_BITS-1:0]  ch;
        logic                  is_count;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } t_out_byte;

    t_out_byte             printed_q[$];
    t_parse_mode           parse_mode;
    logic                  pad_with_zero;
    int unsigned           field_width;
    logic [COUNT_BITS-1:0] bytes_out;
    int                    fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void clear_string_state();
        parse_mode    = PM_LITERAL;
        pad_with_zero = 1'b0;
        field_width   = 0;
        bytes_out     = '0;
    endfunction

    function automatic void print_byte(logic [CHAR_BITS-1:0] ch);
        if (bytes_out != COUNT_MAX)
            bytes_out++;
        printed_q.push_back('{ch: ch, is_count: 1'b0, count: bytes_out, last: 1'b0});
    endfunction

    function automatic void print_number(logic [ARG_BITS-1:0] value, int unsigned base);
        logic [CHAR_BITS-1:0] digs[32];
        logic [ARG_BITS-1:0]  d;
        int                   n;
        int                   pad;
        int                   i;
        n = 0;
        do begin
            d = value % base;
            digs[n] = (d < 10) ? CH_ZERO + d[7:0] : CH_HEX_OFS + d[7:0];
            n++;
            value = value / base;
        end while (value != 0);
        pad = (field_width > n) ? field_width - n : 0;
        for (i = 0; i < pad; i++)
            print_byte(pad_with_zero ? CH_ZERO : CH_SPACE);
        for (i = n - 1; i >= 0; i--)
            print_byte(digs[i]);
    endfunction

    // Expands one format byte into the output bytes it causes.
    function automatic void format_one(logic [CHAR_BITS-1:0] c, logic [ARG_BITS-1:0] arg,
                                       logic first);
        int        depth_at_entry;
        t_out_byte tail;
        int unsigned w;
        if (first)
            clear_string_state();
        depth_at_entry = printed_q.size();
        if (parse_mode == PM_LITERAL) begin
            if (c == CH_PERCENT) begin
                parse_mode    = PM_SPEC;
                pad_with_zero = 1'b0;
                field_width   = 0;
            end else begin
                print_byte(c);
            end
        end else if (parse_mode == PM_SPEC && c == CH_ZERO) begin
            pad_with_zero = 1'b1;
            parse_mode    = PM_WIDTH;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            w = field_width * 10 + (c - CH_ZERO);
            field_width = (w > MAX_WIDTH) ? MAX_WIDTH : w;
            parse_mode  = PM_WIDTH;
        end else begin
            parse_mode = PM_LITERAL;
            case (c)
                CH_D: begin
                    if (arg[ARG_BITS-1]) begin
                        print_byte(CH_MINUS);
                        arg = -arg;
                    end
                    print_number(arg, 10);
                end
                CH_U:       print_number(arg, 10);
                CH_X:       print_number(arg, 16);
                CH_C:       print_byte(arg[7:0]);
                CH_PERCENT: print_byte(CH_PERCENT);
                CH_N: begin
                    printed_q.push_back('{ch: '0, is_count: 1'b1, count: bytes_out,
                                          last: 1'b0});
                end
                default: ;
            endcase
        end
        if (printed_q.size() > depth_at_entry) begin
            tail = printed_q.pop_back();
            tail.last = 1'b1;
            printed_q.push_back(tail);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_byte want;
        t_out_byte got;
        if (!i_rst_n) begin
            clear_string_state();
            printed_q.delete();
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                format_one(i_s_tdata[7:0], i_s_tdata[39:8], i_s_tuser);
            if (i_m_tvalid && i_m_tready) begin
                got = '{ch: i_m_tdata[7:0], is_count: i_m_tuser, count: i_m_tdata[38:8],
                        last: i_m_tlast};
                if (printed_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 40)
                        $display("%0t ERROR: unexpected char=%h is_count=%b count=%0d last=%b",
                                 $time, got.ch, got.is_count, got.count, got.last);
                end else begin
                    want = printed_q.pop_front();
                    if (got.ch !== want.ch || got.is_count !== want.is_count ||
                        got.count !== want.count || got.last !== want.last ||
                        i_m_tdata[39] !== 1'b0) begin
                        fail_count++;
                        if (fail_count <= 40)
                            $display("%0t ERROR: exp %h/%b/%0d/%b/0 got %h/%b/%0d/%b/%b",
                                     $time, want.ch, want.is_count, want.count, want.last,
                                     got.ch, got.is_count, got.count, got.last,
                                     i_m_tdata[39]);
                    end
                end
            end
            o_pending <= printed_q.size();
        end
    end

endmodule

/* dv/format_string_printer_unit_tb.sv */
// Testbench top for the format string printer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module format_string_printer_unit_tb;
    import fsp_pkg::*;

    localparam int                   RUN_ITEMS   = 360;
    localparam int                   CYCLE_LIMIT = 2_000_000;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_S  = 8'h73;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic                     s_tuser = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tuser;
    logic                     m_tlast;
    logic                     burst = 1'b0;
    int                       fail_count;
    int                       pending;
    int                       items_sent = 0;
    int                       cycles = 0;
    int                       ready_hold = 0;

    always #2 i_clk = ~i_clk;

    format_string_printer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    format_string_printer_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output back-pressure: runs of ready and stall, mostly short, some long.
    always @(posedge i_clk) begin : sink_pace
        int unsigned pick;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (burst || pick < 60) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 8);
            end else if (pick < 93) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(8, 30);
            end
        end
    end

    function automatic int pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 65)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [ARG_BITS-1:0] pick_arg();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(0, 99);
            4:       return -$urandom_range(1, 999);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CHAR_BITS-1:0] pick_conversion();
        case ($urandom_range(0, 11))
            0, 1:    return CH_D;
            2, 3:    return CH_U;
            4, 5:    return CH_X;
            6:       return CH_C;
            7:       return CH_PERCENT;
            8:       return CH_N;
            9:       return CH_LOWER_S;
            default: return CHAR_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send(input logic [CHAR_BITS-1:0] ch, input logic [ARG_BITS-1:0] arg,
                        input logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {arg, ch};
        s_tuser  <= first;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    initial begin : stimulus
        logic first;
        int unsigned pick;
        int unsigned n;
        int unsigned i;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes, signed extremes, padding, saturated width, odd letters.
        send("A", 32'h1234_5678, 1'b1);
        send(8'h00, '0, 1'b0);
        send(8'hFF, '1, 1'b0);
        send(CH_PERCENT, '0, 1'b0);
        send(CH_D, 32'h8000_0000, 1'b0);
        send(CH_PERCENT, '0, 1'b0);
        send(CH_U, 32'hFFFF_FFFF, 1'b0);
        send(CH_PERCENT, '0, 1'b0);
        send(CH_ZERO, '0, 1'b0);
        send("5", '0, 1'b0);
        send(CH_D, 32'hFFFF_FFD6, 1'b0);
        send(CH_PERCENT, '0, 1'b0);
        send(CH_NINE, '0, 1'b0);
        send(CH_NINE, '0, 1'b0);
        send(CH_X, '0, 1'b0);
        send(CH_PERCENT, '0, 1'b0);
        send(CH_PERCENT, '1, 1'b0);
        send(CH_PERCENT, '0, 1'b0);
        send(CH_C, 32'h5555_55AB, 1'b0);
        send(CH_PERCENT, '0, 1'b0);
        send(CH_N, '0, 1'b0);
        send(CH_PERCENT, '0, 1'b0);
        send(CH_LOWER_S, 32'hDEAD_BEEF, 1'b0);
        send("B", '0, 1'b1);

        // Random: mostly well-formed conversion specs, plus literal runs and loose bytes.
        while (items_sent < RUN_ITEMS) begin
            if ($urandom_range(0, 19) == 0)
                burst <= ~burst;
            first = ($urandom_range(0, 29) == 0);
            pick  = $urandom_range(0, 99);
            if (pick < 65) begin
                send(CH_PERCENT, $urandom, first);
                if ($urandom_range(0, 1) == 1)
                    send(CH_ZERO, $urandom, 1'b0);
                n = ($urandom_range(0, 9) < 2) ? 2 : $urandom_range(0, 1);
                for (i = 0; i < n; i++)
                    send(CHAR_BITS'($urandom_range(CH_ZERO, CH_NINE)), $urandom, 1'b0);
                send(pick_conversion(), pick_arg(), 1'b0);
            end else if (pick < 90) begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    send(CHAR_BITS'($urandom_range(0, 255)), $urandom, (i == 0) && first);
            end else begin
                send(CHAR_BITS'($urandom_range(0, 255)), pick_arg(),
                     ($urandom_range(0, 1) == 1));
            end
        end
        s_tvalid <= 1'b0;
        burst    <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
